@@ hw/rtl/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and helpers for the Mandelbrot escape-time pixel
// unit: field widths, register map, reset values and coordinate saturation.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // Image and number format.
  localparam int IMG_WIDTH  = 512;
  localparam int IMG_HEIGHT = 512;
  localparam int FRAC_BITS  = 28;

  // Field widths.
  localparam int COL_W   = 9;
  localparam int ROW_W   = 9;
  localparam int COORD_W = 32;
  localparam int STEP_W  = 31;
  localparam int COUNT_W = 16;
  localparam int BOUND_W = 32;
  localparam int COLOR_W = 8;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register map, indexed by paddr[4:2].
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_REAL_MIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAG_MIN   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_REAL  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_IMAG  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ESC_BOUND  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OUT_GREEN  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_OUT_BLUE   = 3'd7;

  // Reset values.
  localparam logic [COORD_W-1:0] RST_REAL_MIN   = 32'hD800_0000;  // -2.5
  localparam logic [COORD_W-1:0] RST_IMAG_MIN   = 32'hE000_0000;  // -2.0
  localparam logic [STEP_W-1:0]  RST_STEP_REAL  = 31'd2097152;
  localparam logic [STEP_W-1:0]  RST_STEP_IMAG  = 31'd2097152;
  localparam logic [COUNT_W-1:0] RST_ITER_LIMIT = 16'd200;
  localparam logic [BOUND_W-1:0] RST_ESC_BOUND  = 32'h4000_0000;  // 4.0
  localparam logic [COLOR_W-1:0] RST_OUT_GREEN  = 8'd0;
  localparam logic [COLOR_W-1:0] RST_OUT_BLUE   = 8'd100;

  // Colors.
  localparam logic [COLOR_W-1:0] COLOR_FULL  = 8'd255;
  localparam logic [COLOR_W-1:0] COLOR_NONE  = 8'd0;

  // Datapath widths.
  localparam int PROD_W  = 2 * COORD_W;               // full square / cross product
  localparam int ZSQ_W   = PROD_W - FRAC_BITS;        // square after truncation
  localparam int CROSS_W = PROD_W - FRAC_BITS + 1;    // 2*zx*zy after truncation
  localparam int MAP_W   = COL_W + STEP_W;            // index times step
  localparam int SUM_W   = MAP_W + 2;                 // mapped coordinate before saturation
  localparam int ITER_W  = CROSS_W + 2;               // next z before saturation
  localparam int SAT_W   = (SUM_W > ITER_W) ? SUM_W : ITER_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [COORD_W-1:0] real_min;
    logic [COORD_W-1:0] imag_min;
    logic [STEP_W-1:0]  step_real;
    logic [STEP_W-1:0]  step_imag;
    logic [COUNT_W-1:0] iteration_limit;
    logic [BOUND_W-1:0] escape_bound_sq;
    logic [COLOR_W-1:0] outside_green;
    logic [COLOR_W-1:0] outside_blue;
  } cfg_t;

  // Mapped point c handed from the front end to the iteration engine.
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } point_t;

  // Clamp a wide signed value to the signed coordinate range.
  function automatic logic [COORD_W-1:0] sat_coord(input logic [SAT_W-1:0] x);
    logic [SAT_W-COORD_W:0] upper;
    logic [COORD_W-1:0]     result;
    upper = x[SAT_W-1:COORD_W-1];
    if ((&upper) || !(|upper)) begin
      result = x[COORD_W-1:0];
    end else if (x[SAT_W-1]) begin
      result = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return result;
  endfunction

endpackage

@@ hw/rtl/mbe_front.sv @@
// ----------------------------------------------------------------------------
// mbe_front
// Pixel intake: clamps the indices, maps them to the complex point c through
// a multiply stage and a sum stage, snaps a near-zero imaginary part, and
// pushes the saturated point into the queue.
// ----------------------------------------------------------------------------
module mbe_front import mbe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  logic [COL_W-1:0] pixel_col,
  input  logic [ROW_W-1:0] pixel_row,
  output logic             push,
  output point_t           push_data,
  input  logic             full
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_SUM  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t state;
  front_state_t state_next;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [MAP_W-1:0] prod_re;
  logic [MAP_W-1:0] prod_im;
  logic [SUM_W-1:0] sum_re;
  logic [SUM_W-1:0] sum_im;

  logic [COL_W-1:0] col_clamped;
  logic [ROW_W-1:0] row_clamped;
  logic [SUM_W-1:0] cy_mag;
  logic             snap;
  logic [SAT_W-1:0] cy_wide;

  assign pixel_stall = (state != F_IDLE);

  always_comb begin
    col_clamped = pixel_col;
    row_clamped = pixel_row;
    if (32'(pixel_col) >= 32'(IMG_WIDTH)) begin
      col_clamped = COL_W'(IMG_WIDTH - 1);
    end
    if (32'(pixel_row) >= 32'(IMG_HEIGHT)) begin
      row_clamped = ROW_W'(IMG_HEIGHT - 1);
    end
  end

  // An imaginary part within half a row step of zero is taken as zero.
  always_comb begin
    cy_mag = sum_im[SUM_W-1] ? (~sum_im + SUM_W'(1)) : sum_im;
    snap   = {cy_mag, 1'b0} < {{(SUM_W+1-STEP_W){1'b0}}, cfg.step_imag};
    cy_wide = snap ? '0 : SAT_W'($signed(sum_im));
  end

  assign push         = (state == F_PUSH) && !full;
  assign push_data.cx = sat_coord(SAT_W'($signed(sum_re)));
  assign push_data.cy = sat_coord(cy_wide);

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (pixel_valid) begin
          state_next = F_MUL;
        end
      end
      F_MUL:  state_next = F_SUM;
      F_SUM:  state_next = F_PUSH;
      F_PUSH: begin
        if (!full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && pixel_valid) begin
      col <= col_clamped;
      row <= row_clamped;
    end
    if (state == F_MUL) begin
      prod_re <= MAP_W'(col) * MAP_W'(cfg.step_real);
      prod_im <= MAP_W'(row) * MAP_W'(cfg.step_imag);
    end
    if (state == F_SUM) begin
      sum_re <= {{(SUM_W-COORD_W){cfg.real_min[COORD_W-1]}}, cfg.real_min}
                + {2'b00, prod_re};
      sum_im <= {{(SUM_W-COORD_W){cfg.imag_min[COORD_W-1]}}, cfg.imag_min}
                + {2'b00, prod_im};
    end
  end

endmodule

@@ hw/rtl/mbe_queue.sv @@
// ----------------------------------------------------------------------------
// mbe_queue
// Short first-in first-out queue of mapped points between the front end and
// the iteration engine.
// ----------------------------------------------------------------------------
module mbe_queue import mbe_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  point_t push_data,
  output logic   full,
  input  logic   pop,
  output point_t pop_data,
  output logic   empty
);

  point_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;

  assign full     = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hw/rtl/mbe_back.sv @@
// ----------------------------------------------------------------------------
// mbe_back
// Iteration engine: runs z = z^2 + c, each iteration a products state
// (B_MUL) then a truncation, escape test and update state (B_ADD), and holds
// the finished result in an output register.
// ----------------------------------------------------------------------------
module mbe_back import mbe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               empty,
  input  point_t             pop_data,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [COUNT_W-1:0] iter_count,
  output logic               inside_res,
  output logic [COLOR_W-1:0] red,
  output logic [COLOR_W-1:0] green,
  output logic [COLOR_W-1:0] blue
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_ADD  = 3'b100
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  logic [COORD_W-1:0]        cx;
  logic [COORD_W-1:0]        cy;
  logic signed [COORD_W-1:0] zx;
  logic signed [COORD_W-1:0] zy;
  logic signed [PROD_W-1:0]  pxx;
  logic signed [PROD_W-1:0]  pyy;
  logic signed [PROD_W-1:0]  pxy;
  logic [COUNT_W-1:0]        count;

  logic [ZSQ_W-1:0]   zx2;
  logic [ZSQ_W-1:0]   zy2;
  logic [CROSS_W-1:0] xy2;
  logic [ZSQ_W:0]     mag;
  logic               done;
  logic               in_set;
  logic               out_free;
  logic               finish;
  logic [SAT_W-1:0]   zx_wide;
  logic [SAT_W-1:0]   zy_wide;

  always_comb begin
    zx2   = pxx[PROD_W-1:FRAC_BITS];
    zy2   = pyy[PROD_W-1:FRAC_BITS];
    // Arithmetic right shift by one bit less gives 2*zx*zy rounded down.
    xy2   = pxy[PROD_W-1:FRAC_BITS-1];
    mag   = {1'b0, zx2} + {1'b0, zy2};
    done  = (count >= cfg.iteration_limit)
            || (mag >= {{(ZSQ_W+1-BOUND_W){1'b0}}, cfg.escape_bound_sq});
    in_set = (count == cfg.iteration_limit);
    zx_wide = {{(SAT_W-ZSQ_W){1'b0}}, zx2} - {{(SAT_W-ZSQ_W){1'b0}}, zy2}
              + {{(SAT_W-COORD_W){cx[COORD_W-1]}}, cx};
    zy_wide = {{(SAT_W-CROSS_W){xy2[CROSS_W-1]}}, xy2}
              + {{(SAT_W-COORD_W){cy[COORD_W-1]}}, cy};
  end

  assign out_free = !result_valid || !result_stall;
  assign finish   = (state == B_ADD) && done && out_free;
  assign pop      = (state == B_IDLE) && !empty;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!empty) begin
          state_next = B_MUL;
        end
      end
      B_MUL: state_next = B_ADD;
      B_ADD: begin
        if (!done) begin
          state_next = B_MUL;
        end else if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cx    <= pop_data.cx;
      cy    <= pop_data.cy;
      zx    <= '0;
      zy    <= '0;
      count <= '0;
    end
    if (state == B_MUL) begin
      pxx <= zx * zx;
      pyy <= zy * zy;
      pxy <= zx * zy;
    end
    if (state == B_ADD && !done) begin
      zx    <= sat_coord(zx_wide);
      zy    <= sat_coord(zy_wide);
      count <= count + COUNT_W'(1);
    end
    if (finish) begin
      iter_count <= count;
      inside_res <= in_set;
      red        <= in_set ? COLOR_FULL : COLOR_NONE;
      green      <= in_set ? COLOR_FULL : cfg.outside_green;
      blue       <= in_set ? COLOR_FULL : cfg.outside_blue;
    end
  end

endmodule

@@ hw/rtl/mandelbrot_escape_time_pixel.sv @@
// Flow: a pixel is mapped through the multiply, sum and push states, popped
// into the engine, then iterated in alternating multiply and add states for n
// iterations plus a final pass that detects the end; that pass loads the result
// register once it is free of result_stall, and result_valid rises.
// The engine takes a new point only after finishing the last; mapping of the
// next pixel overlaps through a two-entry queue.
// Reset: synchronous; clears the queue and control state, loads register defaults.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time pixel unit: configuration registers, pixel mapping front end,
// point queue and iteration engine.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel import mbe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  logic [COL_W-1:0]   pixel_col,
  input  logic [ROW_W-1:0]   pixel_row,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [COUNT_W-1:0] iter_count,
  output logic               inside_res,
  output logic [COLOR_W-1:0] red,
  output logic [COLOR_W-1:0] green,
  output logic [COLOR_W-1:0] blue
);

  cfg_t                 cfg;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 push;
  point_t               push_data;
  logic                 full;
  logic                 pop;
  point_t               pop_data;
  logic                 empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.real_min        <= RST_REAL_MIN;
      cfg.imag_min        <= RST_IMAG_MIN;
      cfg.step_real       <= RST_STEP_REAL;
      cfg.step_imag       <= RST_STEP_IMAG;
      cfg.iteration_limit <= RST_ITER_LIMIT;
      cfg.escape_bound_sq <= RST_ESC_BOUND;
      cfg.outside_green   <= RST_OUT_GREEN;
      cfg.outside_blue    <= RST_OUT_BLUE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_REAL_MIN:   cfg.real_min        <= pwdata;
        REG_IMAG_MIN:   cfg.imag_min        <= pwdata;
        REG_STEP_REAL:  cfg.step_real       <= pwdata[STEP_W-1:0];
        REG_STEP_IMAG:  cfg.step_imag       <= pwdata[STEP_W-1:0];
        REG_ITER_LIMIT: cfg.iteration_limit <= pwdata[COUNT_W-1:0];
        REG_ESC_BOUND:  cfg.escape_bound_sq <= pwdata[BOUND_W-1:0];
        REG_OUT_GREEN:  cfg.outside_green   <= pwdata[COLOR_W-1:0];
        REG_OUT_BLUE:   cfg.outside_blue    <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_REAL_MIN:   prdata = cfg.real_min;
      REG_IMAG_MIN:   prdata = cfg.imag_min;
      REG_STEP_REAL:  prdata = DATA_W'(cfg.step_real);
      REG_STEP_IMAG:  prdata = DATA_W'(cfg.step_imag);
      REG_ITER_LIMIT: prdata = DATA_W'(cfg.iteration_limit);
      REG_ESC_BOUND:  prdata = DATA_W'(cfg.escape_bound_sq);
      REG_OUT_GREEN:  prdata = DATA_W'(cfg.outside_green);
      REG_OUT_BLUE:   prdata = DATA_W'(cfg.outside_blue);
      default:        prdata = '0;
    endcase
  end

  mbe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .push        (push),
    .push_data   (push_data),
    .full        (full)
  );

  mbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  mbe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .empty        (empty),
    .pop_data     (pop_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .iter_count   (iter_count),
    .inside_res   (inside_res),
    .red          (red),
    .green        (green),
    .blue         (blue)
  );

endmodule
